// ----- rtl/two_level_lru_cache_hierarchy_top_defines.svh -----
// ---------------------------------------------------------------------------
// two-level lru cache hierarchy assertion macros
// shared assertion forms used at the top level
// ---------------------------------------------------------------------------
`ifndef TWO_LEVEL_LRU_CACHE_HIERARCHY_TOP_DEFINES_SVH
`define TWO_LEVEL_LRU_CACHE_HIERARCHY_TOP_DEFINES_SVH

// same-cycle implication
`define TLLC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tllc assertion failed");

// next-cycle implication
`define TLLC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tllc assertion failed");

`endif

// ----- rtl/tllc_pkg.sv -----
// ---------------------------------------------------------------------------
// tllc package
// types and constants of the two-level lru cache hierarchy
// ---------------------------------------------------------------------------
package tllc_pkg;

  localparam int ADDR_W      = 64;
  localparam int OFF_BITS    = 6;
  localparam int L2_SET_BITS = 10;
  localparam int L3_SET_BITS = 11;
  localparam int L2_SETS     = 1 << L2_SET_BITS;
  localparam int L3_SETS     = 1 << L3_SET_BITS;
  localparam int L2_WAYS     = 8;
  localparam int L3_WAYS     = 16;
  localparam int L2_WAY_W    = $clog2(L2_WAYS);
  localparam int WAY_W       = $clog2(L3_WAYS);
  localparam int L2_TAG_W    = ADDR_W - OFF_BITS - L2_SET_BITS;
  localparam int L3_TAG_W    = ADDR_W - OFF_BITS - L3_SET_BITS;
  localparam int STAMP_W     = 64;
  localparam int CNT_W       = L3_SET_BITS;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              counts;
  } in_t;

  typedef struct packed {
    logic l2_hit;
    logic l3_looked_up;
    logic l3_hit;
  } out_t;

  typedef struct packed {
    logic                valid;
    logic [L2_TAG_W-1:0] tag;
    logic [STAMP_W-1:0]  stamp;
  } l2_line_t;

  typedef struct packed {
    logic                valid;
    logic [L3_TAG_W-1:0] tag;
    logic [STAMP_W-1:0]  stamp;
  } l3_line_t;

  typedef l2_line_t [L2_WAYS-1:0] l2_row_t;
  typedef l3_line_t [L3_WAYS-1:0] l3_row_t;

  typedef struct packed {
    logic             clr;
    logic [CNT_W-1:0] clr_idx;
    logic             load;
    logic             look;
    logic             scan;
    logic [WAY_W-1:0] way;
    logic             commit;
    logic             emit;
  } cmd_t;

  typedef struct packed {
    logic hit2;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/tllc_ram.sv -----
// ---------------------------------------------------------------------------
// tllc ram
// generic one-write one-read memory with registered read data
// ---------------------------------------------------------------------------
module tllc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic                 re_i,
  input  logic [AW-1:0]        raddr_i,
  output logic [WIDTH-1:0]     rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ----- rtl/tllc_ctrl.sv -----
// ---------------------------------------------------------------------------
// tllc controller
// sequences clearing, lookup, victim scan, write-back and result delivery
// ---------------------------------------------------------------------------
module tllc_ctrl
  import tllc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_counts_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);
  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_LOOK   = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.clr_idx = cnt_q;
    cmd_o.way     = cnt_q[WAY_W-1:0];
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(L3_SETS - 1)) begin
          state_d = S_IDLE;
          cnt_d   = '0;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = in_counts_i ? S_LOOK : S_DONE;
        end
      end
      S_LOOK: begin
        cmd_o.look = 1'b1;
        cnt_d = CNT_W'(1);
        state_d = sts_i.hit2 ? S_COMMIT : S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(L3_WAYS - 1)) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end
endmodule

// ----- rtl/tllc_dpath.sv -----
// ---------------------------------------------------------------------------
// tllc datapath
// set memories, tag match, oldest-stamp scan, line update and result register
// ---------------------------------------------------------------------------
module tllc_dpath
  import tllc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  in_t  in_data_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);
  in_t                 req_q;
  l2_row_t             row2, wrow2;
  l3_row_t             row3, wrow3;
  logic [STAMP_W-1:0]  gstamp_q;
  logic                hit2_q, hit3_q;
  logic [L2_WAY_W-1:0] hw2_q, best2_q, inv2_idx_q;
  logic [WAY_W-1:0]    hw3_q, best3_q, inv3_idx_q;
  logic                inv2_q, inv3_q;
  logic [STAMP_W-1:0]  bst2_q, bst3_q;
  logic                out_valid_q;
  out_t                out_q, res_q;

  logic [L2_TAG_W-1:0] tag2;
  logic [L3_TAG_W-1:0] tag3;
  logic                hit2, hit3, inv2, inv3;
  logic [L2_WAY_W-1:0] hw2, inv2_idx, v2;
  logic [WAY_W-1:0]    hw3, inv3_idx, v3;
  logic                we2, we3;
  logic [L2_SET_BITS-1:0] waddr2;
  logic [L3_SET_BITS-1:0] waddr3;
  logic [$bits(l2_row_t)-1:0] rdata2;
  logic [$bits(l3_row_t)-1:0] rdata3;

  assign tag2 = req_q.address[ADDR_W-1:OFF_BITS+L2_SET_BITS];
  assign tag3 = req_q.address[ADDR_W-1:OFF_BITS+L3_SET_BITS];
  assign row2 = l2_row_t'(rdata2);
  assign row3 = l3_row_t'(rdata3);

  // tag match and lowest free way
  always_comb begin
    hit2 = 1'b0; hw2 = '0; inv2 = 1'b0; inv2_idx = '0;
    for (int w = L2_WAYS - 1; w >= 0; w--) begin
      if (row2[w].valid && row2[w].tag == tag2) begin
        hit2 = 1'b1; hw2 = L2_WAY_W'(w);
      end
      if (!row2[w].valid) begin
        inv2 = 1'b1; inv2_idx = L2_WAY_W'(w);
      end
    end
    hit3 = 1'b0; hw3 = '0; inv3 = 1'b0; inv3_idx = '0;
    for (int w = L3_WAYS - 1; w >= 0; w--) begin
      if (row3[w].valid && row3[w].tag == tag3) begin
        hit3 = 1'b1; hw3 = WAY_W'(w);
      end
      if (!row3[w].valid) begin
        inv3 = 1'b1; inv3_idx = WAY_W'(w);
      end
    end
  end

  assign v2 = inv2_q ? inv2_idx_q : best2_q;
  assign v3 = inv3_q ? inv3_idx_q : best3_q;

  // row update and write control
  always_comb begin
    wrow2 = row2;
    wrow3 = row3;
    if (hit2_q) begin
      wrow2[hw2_q].stamp = gstamp_q + STAMP_W'(1);
    end else begin
      if (hit3_q) begin
        wrow3[hw3_q].stamp = gstamp_q + STAMP_W'(1);
      end else begin
        wrow3[v3] = '{valid: 1'b1, tag: tag3, stamp: gstamp_q + STAMP_W'(1)};
      end
      wrow2[v2] = '{valid: 1'b1, tag: tag2, stamp: gstamp_q + STAMP_W'(2)};
    end
    if (cmd_i.clr) begin
      wrow2 = '0;
      wrow3 = '0;
    end
  end

  assign we2 = cmd_i.commit ||
               (cmd_i.clr && cmd_i.clr_idx[CNT_W-1:L2_SET_BITS] == '0);
  assign we3 = cmd_i.commit || cmd_i.clr;
  assign waddr2 = cmd_i.clr ? cmd_i.clr_idx[L2_SET_BITS-1:0]
                            : req_q.address[OFF_BITS+L2_SET_BITS-1:OFF_BITS];
  assign waddr3 = cmd_i.clr ? cmd_i.clr_idx[L3_SET_BITS-1:0]
                            : req_q.address[OFF_BITS+L3_SET_BITS-1:OFF_BITS];

  tllc_ram #(.WIDTH($bits(l2_row_t)), .DEPTH(L2_SETS)) u_l2_ram (
    .clk_i   (clk_i),
    .we_i    (we2),
    .waddr_i (waddr2),
    .wdata_i (wrow2),
    .re_i    (cmd_i.load),
    .raddr_i (in_data_i.address[OFF_BITS+L2_SET_BITS-1:OFF_BITS]),
    .rdata_o (rdata2)
  );

  tllc_ram #(.WIDTH($bits(l3_row_t)), .DEPTH(L3_SETS)) u_l3_ram (
    .clk_i   (clk_i),
    .we_i    (we3),
    .waddr_i (waddr3),
    .wdata_i (wrow3),
    .re_i    (cmd_i.load),
    .raddr_i (in_data_i.address[OFF_BITS+L3_SET_BITS-1:OFF_BITS]),
    .rdata_o (rdata3)
  );

  // request, lookup, scan and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_data_i;
      res_q <= '0;
    end
    if (cmd_i.look) begin
      hit2_q     <= hit2;
      hit3_q     <= hit3;
      hw2_q      <= hw2;
      hw3_q      <= hw3;
      inv2_q     <= inv2;
      inv3_q     <= inv3;
      inv2_idx_q <= inv2_idx;
      inv3_idx_q <= inv3_idx;
      best2_q    <= '0;
      best3_q    <= '0;
      bst2_q     <= row2[0].stamp;
      bst3_q     <= row3[0].stamp;
      res_q      <= '{l2_hit: hit2, l3_looked_up: !hit2, l3_hit: !hit2 && hit3};
    end
    if (cmd_i.scan) begin
      if (int'(cmd_i.way) < L2_WAYS &&
          row2[cmd_i.way[L2_WAY_W-1:0]].stamp < bst2_q) begin
        bst2_q  <= row2[cmd_i.way[L2_WAY_W-1:0]].stamp;
        best2_q <= cmd_i.way[L2_WAY_W-1:0];
      end
      if (row3[cmd_i.way].stamp < bst3_q) begin
        bst3_q  <= row3[cmd_i.way].stamp;
        best3_q <= cmd_i.way;
      end
    end
    if (cmd_i.emit) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gstamp_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        gstamp_q <= gstamp_q + (hit2_q ? STAMP_W'(1) : STAMP_W'(2));
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.hit2     = hit2;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;
endmodule

// ----- rtl/two_level_lru_cache_hierarchy_top.sv -----
// ---------------------------------------------------------------------------
// two-level lru cache hierarchy
// 8-way l2 and 16-way l3 tag model with global-stamp lru, one result a request
// ---------------------------------------------------------------------------
// input channel: in_valid_i / in_stall_o carry in_data_i (address, counts);
// a request is taken when valid is high and stall is low.
// output channel: out_valid_o / out_stall_i carry out_data_o (l2_hit,
// l3_looked_up, l3_hit), one result for every request, in order.
// one request is worked on at a time; each level keeps a set row in one
// memory and both levels are read in the accept cycle.
// skipped request (counts low): no lookup and no row write; the result is all clear.
// l2 hit: read, match, row write, result.
// l2 miss: the oldest-stamp search walks one way per cycle
// over 15 ways, then both rows are written together.
// after reset a clearing pass writes the 2048 l3 rows and, in parallel,
// the 1024 l2 rows, during which in_stall_o stays high.
// while the receiver stalls the result is held and a new request may be
// taken; a further result waits until the output register is free.
// ---------------------------------------------------------------------------
`include "two_level_lru_cache_hierarchy_top_defines.svh"

module two_level_lru_cache_hierarchy_top
  import tllc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);
  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign in_stall_o = !in_ready;

  tllc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_counts_i (in_data_i.counts),
    .in_ready_o  (in_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tllc_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  `TLLC_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  `TLLC_ASSERT_IMP(a_l3_hit_needs_lookup, out_valid_o && out_data_o.l3_hit,
                   out_data_o.l3_looked_up)
  `TLLC_ASSERT_IMP(a_l2_hit_no_lookup, out_valid_o && out_data_o.l2_hit,
                   !out_data_o.l3_looked_up)
  `TLLC_ASSERT_IMP(a_write_not_during_clear, cmd.commit, !cmd.clr && !cmd.load)
endmodule
